[sv/iia_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iia_pkg
// Shared types and constants of the interrupt input allocator.
// ----------------------------------------------------------------------------
package iia_pkg;

    localparam int NUM_W     = 10;
    localparam int NUM_LIMIT = 1024;
    localparam int CFG_DEVS  = 4;
    localparam int DEV_IDX_W = 2;
    localparam int BASE_W    = 10;
    localparam int COUNT_W   = 6;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 3;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    typedef enum logic [REQ_W-1:0] {
        REQ_ANY      = 2'd0,
        REQ_SPECIFIC = 2'd1,
        REQ_FREE     = 2'd2,
        REQ_UNUSED   = 2'd3
    } t_req_type;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED   = 3'd0,
        ST_BUSY      = 3'd1,
        ST_NONE_FREE = 3'd2,
        ST_NO_RANGE  = 3'd3,
        ST_FREED     = 3'd4
    } t_status;

    typedef enum logic {
        REG_SEL_BASE  = 1'b0,
        REG_SEL_COUNT = 1'b1
    } t_reg_sel;

endpackage
`default_nettype wire

[sv/iia_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iia_req_if / iia_res_if
// Request and result channels of the interrupt input allocator.
// ----------------------------------------------------------------------------
interface iia_req_if
    import iia_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [NUM_W-1:0] input_number;

    modport source (output valid, output req_type, output input_number, input ready);
    modport sink   (input valid, input req_type, input input_number, output ready);
endinterface

interface iia_res_if
    import iia_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [NUM_W-1:0]    granted_number;

    modport source (output valid, output status, output granted_number, input ready);
    modport sink   (input valid, input status, input granted_number, output ready);
endinterface
`default_nettype wire

[sv/interrupt_input_allocator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// interrupt_input_allocator_unit
// Hands out global interrupt input numbers across up to four controllers.
// ----------------------------------------------------------------------------
// Each request is captured in an input register; the range compares and the
// lowest-free priority encoder over all usage bitmaps then run on it, and the
// outcome lands in the result register while the bitmaps update, once the
// result register is free or drains. A new request is taken every cycle as
// long as the result register drains; a stalled result holds the input
// register, so at most two transactions are in flight. Controller d serves
// global numbers base_dev(d) up to base_dev(d) + count_dev(d) - 1, capped at
// MAX_INPUTS inputs and at number 1023; registers sit at byte address 4 * index.
// ----------------------------------------------------------------------------
module interrupt_input_allocator_unit
    import iia_pkg::*;
#(
    parameter int NUM_DEVICES = 4,
    parameter int MAX_INPUTS  = 32
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    iia_req_if.sink          i_req,
    iia_res_if.source        o_res,
    input  wire              psel,
    input  wire              penable,
    input  wire              pwrite,
    input  wire [APB_AW-1:0] paddr,
    input  wire [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic             pready
);

    localparam int NUM_PRES = (NUM_DEVICES < CFG_DEVS) ? NUM_DEVICES : CFG_DEVS;
    localparam int KW       = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int EW       = NUM_W + 1;

    logic [BASE_W-1:0]     r_base  [CFG_DEVS];
    logic [COUNT_W-1:0]    r_count [CFG_DEVS];
    logic [MAX_INPUTS-1:0] r_usage [NUM_PRES];
    logic [MAX_INPUTS-1:0] n_usage [NUM_PRES];

    logic             r_in_valid;
    logic [REQ_W-1:0] r_req;
    logic [NUM_W-1:0] r_num;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [NUM_W-1:0]    r_granted;
    t_status             n_status;
    logic [NUM_W-1:0]    n_granted;

    logic [EW-1:0]         cap   [NUM_PRES];
    logic [EW-1:0]         eff   [NUM_PRES];
    logic [MAX_INPUTS-1:0] avail [NUM_PRES];

    logic                 adv;
    logic                 cfg_wr;
    logic [DEV_IDX_W-1:0] cfg_dev;
    t_reg_sel             cfg_sel;

    assign adv     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || adv;

    assign o_res.valid          = r_out_valid;
    assign o_res.status         = r_status;
    assign o_res.granted_number = r_granted;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_dev = paddr[APB_AW-1:3];
    assign cfg_sel = t_reg_sel'(paddr[2]);

    always_comb begin
        prdata = '0;
        case (cfg_sel)
            REG_SEL_BASE:  prdata = APB_DW'(r_base[cfg_dev]);
            REG_SEL_COUNT: prdata = APB_DW'(r_count[cfg_dev]);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < CFG_DEVS; d++) begin
                r_base[d]  <= '0;
                r_count[d] <= '0;
            end
        end else if (cfg_wr) begin
            case (cfg_sel)
                REG_SEL_BASE:  r_base[cfg_dev]  <= pwdata[BASE_W-1:0];
                REG_SEL_COUNT: r_count[cfg_dev] <= pwdata[COUNT_W-1:0];
                default:       r_base[cfg_dev]  <= r_base[cfg_dev];
            endcase
        end
    end

    // clamp each range to MAX_INPUTS and to the top of the number space
    always_comb begin
        for (int d = 0; d < NUM_PRES; d++) begin
            cap[d] = (EW'(r_count[d]) > EW'(MAX_INPUTS)) ? EW'(MAX_INPUTS)
                                                         : EW'(r_count[d]);
            eff[d] = (EW'(r_base[d]) + cap[d] > EW'(NUM_LIMIT))
                   ? EW'(NUM_LIMIT) - EW'(r_base[d]) : cap[d];
            for (int k = 0; k < MAX_INPUTS; k++) begin
                avail[d][k] = !r_usage[d][k] && (EW'(k) < eff[d]);
            end
        end
    end

    always_comb begin
        logic          found;
        logic [EW-1:0] off;
        found     = 1'b0;
        off       = '0;
        n_status  = ST_NO_RANGE;
        n_granted = '0;
        for (int d = 0; d < NUM_PRES; d++) begin
            n_usage[d] = r_usage[d];
        end
        case (t_req_type'(r_req))
            REQ_ANY: begin
                n_status = ST_NONE_FREE;
                for (int d = 0; d < NUM_PRES; d++) begin
                    for (int k = 0; k < MAX_INPUTS; k++) begin
                        if (!found && avail[d][k]) begin
                            found         = 1'b1;
                            n_usage[d][k] = 1'b1;
                            n_status      = ST_GRANTED;
                            n_granted     = r_base[d] + NUM_W'(k);
                        end
                    end
                end
            end
            REQ_SPECIFIC, REQ_FREE: begin
                for (int d = 0; d < NUM_PRES; d++) begin
                    off = EW'(r_num) - EW'(r_base[d]);
                    if (!found && (r_num >= r_base[d]) && (off < cap[d])) begin
                        found = 1'b1;
                        if (t_req_type'(r_req) == REQ_FREE) begin
                            n_usage[d][off[KW-1:0]] = 1'b0;
                            n_status = ST_FREED;
                        end else if (r_usage[d][off[KW-1:0]]) begin
                            n_status = ST_BUSY;
                        end else begin
                            n_usage[d][off[KW-1:0]] = 1'b1;
                            n_status  = ST_GRANTED;
                            n_granted = r_num;
                        end
                    end
                end
            end
            default: begin
                n_status = ST_NO_RANGE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int d = 0; d < NUM_PRES; d++) begin
                r_usage[d] <= '0;
            end
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                for (int d = 0; d < NUM_PRES; d++) begin
                    r_usage[d] <= n_usage[d];
                end
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_req <= i_req.req_type;
            r_num <= i_req.input_number;
        end
        if (adv) begin
            r_status  <= n_status;
            r_granted <= n_granted;
        end
    end

endmodule
`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the interrupt input allocator.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the controller bases, counts and usage
// bitmaps. It predicts the status and granted number of every accepted
// request and checks each returned result against the oldest prediction.
// A directed part hits the empty, overlapping, capped and cut-off ranges, the
// busy, none-free and not-found outcomes and the unused request type. Random
// phases then reprogram all controllers while idle and send mixed requests,
// with random gaps on the request side and stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;
    import iia_pkg::*;

    localparam int DEV_COUNT     = 4;
    localparam int INPUTS_PER    = 32;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int RAND_PHASES   = 7;
    localparam int PHASE_ITEMS   = 220;
    localparam int REPORT_MAX    = 10;

    class alloc_scoreboard;
        typedef struct {
            t_req_type        req;
            logic [NUM_W-1:0] num;
            t_status          status;
            logic [NUM_W-1:0] number;
        } grant_t;

        logic [BASE_W-1:0]     base_of [CFG_DEVS];
        logic [COUNT_W-1:0]    count_of[CFG_DEVS];
        logic [INPUTS_PER-1:0] used    [CFG_DEVS];
        grant_t                pending_grants[$];
        int                    fail_count;

        function new();
            for (int d = 0; d < CFG_DEVS; d++) begin
                base_of[d]  = '0;
                count_of[d] = '0;
                used[d]     = '0;
            end
            fail_count = 0;
        endfunction

        function void set_register(int idx, logic [APB_DW-1:0] value);
            int d;
            d = idx / 2;
            if (d >= CFG_DEVS) return;
            if ((idx % 2) == int'(REG_SEL_BASE)) base_of[d] = value[BASE_W-1:0];
            else count_of[d] = value[COUNT_W-1:0];
        endfunction

        function int span(int d);
            int c;
            c = int'(count_of[d]);
            if (c > INPUTS_PER) c = INPUTS_PER;
            if (int'(base_of[d]) + c > NUM_LIMIT) c = NUM_LIMIT - int'(base_of[d]);
            return c;
        endfunction

        function int owner(logic [NUM_W-1:0] num);
            for (int d = 0; d < DEV_COUNT && d < CFG_DEVS; d++) begin
                if (int'(num) >= int'(base_of[d]) && int'(num) < int'(base_of[d]) + span(d))
                    return d;
            end
            return -1;
        endfunction

        function void note_request(t_req_type req, logic [NUM_W-1:0] num);
            grant_t g;
            int d;
            int k;
            int c;
            g.req    = req;
            g.num    = num;
            g.status = ST_NO_RANGE;
            g.number = '0;
            case (req)
                REQ_ANY: begin
                    g.status = ST_NONE_FREE;
                    for (d = 0; d < DEV_COUNT && d < CFG_DEVS && g.status == ST_NONE_FREE; d++) begin
                        c = span(d);
                        for (k = 0; k < c; k++) begin
                            if (!used[d][k]) begin
                                used[d][k] = 1'b1;
                                g.number   = NUM_W'(int'(base_of[d]) + k);
                                g.status   = ST_GRANTED;
                                break;
                            end
                        end
                    end
                end
                REQ_SPECIFIC, REQ_FREE: begin
                    d = owner(num);
                    if (d >= 0) begin
                        k = int'(num) - int'(base_of[d]);
                        if (req == REQ_FREE) begin
                            used[d][k] = 1'b0;
                            g.status   = ST_FREED;
                        end else if (used[d][k]) begin
                            g.status = ST_BUSY;
                        end else begin
                            used[d][k] = 1'b1;
                            g.status   = ST_GRANTED;
                            g.number   = num;
                        end
                    end
                end
                default: ;
            endcase
            pending_grants.push_back(g);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [NUM_W-1:0] number);
            grant_t g;
            if (pending_grants.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result: status %0d number %0d", status, number);
                return;
            end
            g = pending_grants.pop_front();
            if (status !== g.status || number !== g.number) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("mismatch for %s %0d: expected %s %0d, got status %0d number %0d",
                             g.req.name(), g.num, g.status.name(), g.number, status, number);
            end
        endfunction

        function int pending();
            return pending_grants.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    iia_req_if req_ch ();
    iia_res_if res_ch ();

    alloc_scoreboard sb = new();

    int cycle_count = 0;
    int gap_pct     = 0;
    int stall_pct   = 0;

    logic [BASE_W-1:0]  phase_base [CFG_DEVS];
    logic [COUNT_W-1:0] phase_count[CFG_DEVS];

    interrupt_input_allocator_unit #(
        .NUM_DEVICES (DEV_COUNT),
        .MAX_INPUTS  (INPUTS_PER)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // stall the result channel in random bursts
    initial begin
        int stall_left;
        stall_left = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                res_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 8);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready)
                sb.check_result(res_ch.status, res_ch.granted_number);
            if (req_ch.valid && req_ch.ready)
                sb.note_request(t_req_type'(req_ch.req_type), req_ch.input_number);
        end
        if (cycle_count > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic apb_write(input int idx, input logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx * 4);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_register(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_device(input int d, input logic [BASE_W-1:0] b,
                                  input logic [COUNT_W-1:0] c);
        phase_base[d]  = b;
        phase_count[d] = c;
        apb_write(2 * d + int'(REG_SEL_BASE), APB_DW'(b));
        apb_write(2 * d + int'(REG_SEL_COUNT), APB_DW'(c));
    endtask

    task automatic send_request(input t_req_type req, input logic [NUM_W-1:0] num);
        int gap;
        if ($urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 9);
            repeat (gap) begin
                @(negedge i_clk);
                req_ch.valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= req;
        req_ch.input_number <= num;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic random_request(input int free_pct);
        int roll;
        int d;
        t_req_type req;
        logic [NUM_W-1:0] num;
        roll = $urandom_range(0, 99);
        if (roll < 6) req = REQ_UNUSED;
        else if (roll < 6 + free_pct) req = REQ_FREE;
        else if (roll < 6 + free_pct + (94 - free_pct) / 2) req = REQ_ANY;
        else req = REQ_SPECIFIC;
        if ($urandom_range(0, 3) != 0) begin
            d   = $urandom_range(0, CFG_DEVS - 1);
            num = NUM_W'(int'(phase_base[d]) + $urandom_range(0, int'(phase_count[d]) + 1));
        end else begin
            num = NUM_W'($urandom_range(0, NUM_LIMIT - 1));
        end
        send_request(req, num);
    endtask

    initial begin
        int pick;
        int center;
        int free_pct;
        logic [BASE_W-1:0]  b;
        logic [COUNT_W-1:0] c;

        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_ANY;
        req_ch.input_number = '0;
        for (int d = 0; d < CFG_DEVS; d++) begin
            phase_base[d]  = '0;
            phase_count[d] = '0;
        end
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every controller absent after reset
        send_request(REQ_ANY, 10'd0);
        send_request(REQ_SPECIFIC, 10'd0);
        send_request(REQ_FREE, 10'd1023);
        send_request(REQ_UNUSED, 10'd512);
        drain();

        // full, cut-off, oversized and overlapping ranges
        program_device(0, 10'd0, 6'd32);
        program_device(1, 10'd1023, 6'd32);
        program_device(2, 10'd40, 6'd63);
        program_device(3, 10'd5, 6'd4);
        gap_pct   = 30;
        stall_pct = 30;
        send_request(REQ_SPECIFIC, 10'd0);
        send_request(REQ_SPECIFIC, 10'd0);
        send_request(REQ_ANY, 10'd1023);
        send_request(REQ_FREE, 10'd0);
        send_request(REQ_FREE, 10'd0);
        send_request(REQ_ANY, 10'd0);
        send_request(REQ_SPECIFIC, 10'd1023);
        send_request(REQ_SPECIFIC, 10'd1022);
        send_request(REQ_FREE, 10'd1023);
        send_request(REQ_SPECIFIC, 10'd71);
        send_request(REQ_SPECIFIC, 10'd72);
        send_request(REQ_SPECIFIC, 10'd7);
        send_request(REQ_UNUSED, 10'd1023);
        send_request(REQ_FREE, 10'd341);
        drain();

        // single input left, then nothing free
        program_device(0, 10'd1023, 6'd1);
        program_device(1, 10'd0, 6'd0);
        program_device(2, 10'd0, 6'd0);
        program_device(3, 10'd0, 6'd0);
        send_request(REQ_ANY, 10'd0);
        send_request(REQ_FREE, 10'd1023);
        send_request(REQ_ANY, 10'd0);
        send_request(REQ_ANY, 10'd0);
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p == 0) begin
                program_device(0, 10'd0, 6'd63);
                program_device(1, 10'd1023, 6'd63);
                program_device(2, 10'd992, 6'd32);
                program_device(3, 10'd1010, 6'd20);
            end else begin
                center = $urandom_range(0, NUM_LIMIT - 1);
                for (int d = 0; d < CFG_DEVS; d++) begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0) b = 10'd0;
                    else if (pick == 1) b = 10'd1023;
                    else if (center + 80 >= NUM_LIMIT) b = BASE_W'(center - $urandom_range(0, 80));
                    else b = BASE_W'(center + $urandom_range(0, 80));
                    pick = $urandom_range(0, 9);
                    if (pick == 0) c = 6'd0;
                    else if (pick == 1) c = 6'd1;
                    else if (pick <= 3) c = 6'd32;
                    else if (pick == 4) c = 6'd63;
                    else c = COUNT_W'($urandom_range(1, 40));
                    program_device(d, b, c);
                end
            end
            case ($urandom_range(0, 2))
                0: free_pct = 15;
                1: free_pct = 30;
                default: free_pct = 45;
            endcase
            if (p == RAND_PHASES - 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = (p % 3 == 1) ? 0 : $urandom_range(5, 35);
                stall_pct = (p % 3 == 2) ? 0 : $urandom_range(5, 35);
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_request(free_pct);
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
sv/iia_pkg.sv
sv/iia_if.sv
sv/interrupt_input_allocator_unit.sv
sim/testbench.sv
